// ===== rtl/cmma_pkg.sv =====
// Shared types, constants and arithmetic helpers for the complex matrix multiply-accumulate block.
package cmma_pkg;

	localparam int MaxDim = 64;
	localparam int FracBits = 30;
	localparam int IdxW = $clog2(MaxDim);
	localparam int AddrW = 2 * IdxW;
	localparam int DimW = 7;

	localparam logic [2:0] ACT_LOAD_A = 3'd0;
	localparam logic [2:0] ACT_LOAD_B = 3'd1;
	localparam logic [2:0] ACT_LOAD_C = 3'd2;
	localparam logic [2:0] ACT_COMPUTE = 3'd3;
	localparam logic [2:0] ACT_READ_C = 3'd4;

	localparam logic [1:0] KIND_ACK = 2'd0;
	localparam logic [1:0] KIND_DATA = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_TRANS = 2'd1;
	localparam logic [1:0] OP_CONJ = 2'd2;

	localparam logic [2:0] REG_ROWS = 3'd0;
	localparam logic [2:0] REG_COLS = 3'd1;
	localparam logic [2:0] REG_DEPTH = 3'd2;
	localparam logic [2:0] REG_OPSEL = 3'd3;
	localparam logic [2:0] REG_ALPHA_RE = 3'd4;
	localparam logic [2:0] REG_ALPHA_IM = 3'd5;
	localparam logic [2:0] REG_BETA_RE = 3'd6;
	localparam logic [2:0] REG_BETA_IM = 3'd7;

	localparam logic signed [33:0] DotLimit = 34'sh0_FFFF_FFFF;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] row_index;
		logic [5:0] col_index;
		logic signed [31:0] value_real;
		logic signed [31:0] value_imag;
	} in_item_t;

	typedef struct packed {
		logic [1:0] reply_kind;
		logic signed [31:0] out_real;
		logic signed [31:0] out_imag;
		logic saturated;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cplx_t;

	typedef struct packed {
		logic [DimW-1:0] rows_m;
		logic [DimW-1:0] cols_n;
		logic [DimW-1:0] depth_k;
		logic [3:0] op_select;
		logic signed [31:0] alpha_real;
		logic signed [31:0] alpha_imag;
		logic signed [31:0] beta_real;
		logic signed [31:0] beta_imag;
	} cfg_t;

	// Rounded product shift: floor((p + 2^(F-1)) / 2^F).
	function automatic logic signed [66:0] rnd_shift(input logic signed [66:0] p);
		logic signed [66:0] t;
		t = p + (67'sd1 <<< (FracBits - 1));
		return t >>> FracBits;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [66:0] v,
			output logic ovf);
		ovf = 1'b0;
		if (v > 67'sd2147483647) begin
			ovf = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -67'sd2147483648) begin
			ovf = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] d);
		return (d > DimW'(MaxDim)) ? DimW'(MaxDim) : d;
	endfunction

endpackage

// ===== rtl/cmma_ram.sv =====
// Single-port-write, one-read synchronous RAM holding complex elements.
module cmma_ram
	import cmma_pkg::*;
(
	input logic clk,
	input logic wr_en,
	input logic [AddrW-1:0] wr_addr,
	input cplx_t wr_data,
	input logic [AddrW-1:0] rd_addr,
	output cplx_t rd_data
);
	cplx_t mem [MaxDim*MaxDim];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

// ===== rtl/cmma_cmul.sv =====
// Pipelined complex multiplier: four real products, rounded, then combined.
module cmma_cmul
	import cmma_pkg::*;
(
	input logic clk,
	input logic signed [33:0] ar,
	input logic signed [33:0] ai,
	input logic signed [33:0] br,
	input logic signed [33:0] bi,
	output logic signed [66:0] re,
	output logic signed [66:0] im
);
	logic signed [66:0] rr_s1, ii_s1, ri_s1, ir_s1;

	always_ff @(posedge clk) begin
		rr_s1 <= rnd_shift(67'(ar * br));
		ii_s1 <= rnd_shift(67'(ai * bi));
		ri_s1 <= rnd_shift(67'(ar * bi));
		ir_s1 <= rnd_shift(67'(ai * br));
	end

	always_ff @(posedge clk) begin
		re <= rr_s1 - ii_s1;
		im <= ri_s1 + ir_s1;
	end
endmodule

// ===== rtl/complex_matrix_multiply_accumulate_top.sv =====
// Top level of the complex matrix multiply-accumulate block.
// Summary for users: the block holds A, B and C (64 x 64 complex Q1.30 each) in three
// synchronous RAMs. Loads and reads take one input item and answer with one result item
// each; the block handles one item at a time. A compute item runs a sequencer over the
// shared complex multiplier: first, unless beta is one, a beta pass over the m x n block
// of C (a read-modify-write of each element through the multiplier), then, unless alpha
// or depth is zero, for each C element k multiply-accumulate steps through the one A and
// one B read port, before the done item appears. Stores are not cleared at reset; reading
// an element never written gives an undefined value. The saturated bit in every result
// reports whether the most recent compute saturated.
module complex_matrix_multiply_accumulate_top
	import cmma_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output out_item_t out_data,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_READ, ST_BETA_RD, ST_BETA_MUL, ST_BETA_WR,
		ST_DOT_INIT, ST_DOT_RUN, ST_DOT_DRAIN, ST_ALPHA_MUL, ST_ALPHA_WR, ST_REPLY
	} state_t;

	state_t state_q;
	cfg_t cfg_q;
	logic sat_q;
	logic [DimW-1:0] m_q, n_q, k_q, i_q, j_q, l_q;
	logic [1:0] opa_q, opb_q;
	logic [3:0] wait_q;
	logic signed [66:0] sum_re_q, sum_im_q;
	logic signed [33:0] acc_re_q, acc_im_q;
	logic [1:0] kind_q;
	cplx_t rdata_q;
	logic valid_s1, valid_s2, valid_s3;

	// Memory ports.
	logic a_we, b_we, c_we;
	logic [AddrW-1:0] ld_addr, a_ra, b_ra, c_ra, c_wa;
	cplx_t a_rd, b_rd, c_rd, c_wd, ld_data;

	// Multiplier ports.
	logic signed [33:0] m_ar, m_ai, m_br, m_bi;
	logic signed [66:0] m_re, m_im;

	logic beta_zero, beta_one, alpha_zero;
	logic ld_hit;
	logic ovf_r, ovf_i;
	logic signed [31:0] sat_r, sat_i;
	logic signed [66:0] dsum_r, dsum_i;
	logic signed [31:0] ar_e, ai_e, br_e, bi_e;

	assign beta_zero = (cfg_q.beta_real == 0) && (cfg_q.beta_imag == 0);
	assign beta_one = (cfg_q.beta_real == (32'sd1 <<< FracBits)) && (cfg_q.beta_imag == 0);
	assign alpha_zero = (cfg_q.alpha_real == 0) && (cfg_q.alpha_imag == 0);

	assign in_ready = (state_q == ST_IDLE);
	assign ld_addr = {in_data.row_index[IdxW-1:0], in_data.col_index[IdxW-1:0]};
	assign ld_hit = (DimW'(in_data.row_index) < DimW'(MaxDim)) &&
		(DimW'(in_data.col_index) < DimW'(MaxDim));
	assign ld_data = '{re: in_data.value_real, im: in_data.value_imag};
	assign a_we = in_valid && in_ready && (in_data.action == ACT_LOAD_A) && ld_hit;
	assign b_we = in_valid && in_ready && (in_data.action == ACT_LOAD_B) && ld_hit;

	// Operand addressing under op(A) and op(B).
	always_comb begin
		if (opa_q == OP_NONE) begin
			a_ra = {i_q[IdxW-1:0], l_q[IdxW-1:0]};
		end else begin
			a_ra = {l_q[IdxW-1:0], i_q[IdxW-1:0]};
		end
		if (opb_q == OP_NONE) begin
			b_ra = {l_q[IdxW-1:0], j_q[IdxW-1:0]};
		end else begin
			b_ra = {j_q[IdxW-1:0], l_q[IdxW-1:0]};
		end
	end

	always_comb begin
		if (state_q == ST_IDLE) begin
			c_ra = ld_addr;
		end else begin
			c_ra = {i_q[IdxW-1:0], j_q[IdxW-1:0]};
		end
	end

	cmma_ram u_a (.clk, .wr_en(a_we), .wr_addr(ld_addr), .wr_data(ld_data),
		.rd_addr(a_ra), .rd_data(a_rd));
	cmma_ram u_b (.clk, .wr_en(b_we), .wr_addr(ld_addr), .wr_data(ld_data),
		.rd_addr(b_ra), .rd_data(b_rd));
	cmma_ram u_c (.clk, .wr_en(c_we), .wr_addr(c_wa), .wr_data(c_wd),
		.rd_addr(c_ra), .rd_data(c_rd));

	// Conjugation applies to the imaginary part of the fetched operand.
	assign ar_e = a_rd.re;
	assign ai_e = (opa_q == OP_CONJ) ? -a_rd.im : a_rd.im;
	assign br_e = b_rd.re;
	assign bi_e = (opb_q == OP_CONJ) ? -b_rd.im : b_rd.im;

	always_comb begin
		case (state_q)
			ST_DOT_RUN, ST_DOT_DRAIN: begin
				m_ar = 34'(ar_e);
				m_ai = (a_rd.im == 32'sh8000_0000 && opa_q == OP_CONJ) ?
					34'sd2147483648 : 34'(ai_e);
				m_br = 34'(br_e);
				m_bi = (b_rd.im == 32'sh8000_0000 && opb_q == OP_CONJ) ?
					34'sd2147483648 : 34'(bi_e);
			end
			ST_ALPHA_MUL, ST_ALPHA_WR: begin
				m_ar = 34'(cfg_q.alpha_real);
				m_ai = 34'(cfg_q.alpha_imag);
				m_br = acc_re_q;
				m_bi = acc_im_q;
			end
			default: begin
				m_ar = 34'(rdata_q.re);
				m_ai = 34'(rdata_q.im);
				m_br = 34'(cfg_q.beta_real);
				m_bi = 34'(cfg_q.beta_imag);
			end
		endcase
	end

	cmma_cmul u_mul (.clk, .ar(m_ar), .ai(m_ai), .br(m_br), .bi(m_bi),
		.re(m_re), .im(m_im));

	// Write-back value: beta result, or C plus alpha times the dot product.
	always_comb begin
		if (state_q == ST_ALPHA_WR) begin
			sat_r = sat32(67'(rdata_q.re) + m_re, ovf_r);
			sat_i = sat32(67'(rdata_q.im) + m_im, ovf_i);
		end else if (beta_zero) begin
			sat_r = '0;
			sat_i = '0;
			ovf_r = 1'b0;
			ovf_i = 1'b0;
		end else begin
			sat_r = sat32(m_re, ovf_r);
			sat_i = sat32(m_im, ovf_i);
		end
	end

	always_comb begin
		if (in_valid && in_ready && in_data.action == ACT_LOAD_C) begin
			c_we = ld_hit;
			c_wa = ld_addr;
			c_wd = ld_data;
		end else begin
			c_we = (state_q == ST_BETA_WR && wait_q == 0) ||
				(state_q == ST_ALPHA_WR && wait_q == 0);
			c_wa = {i_q[IdxW-1:0], j_q[IdxW-1:0]};
			c_wd = '{re: sat_r, im: sat_i};
		end
	end

	assign dsum_r = sum_re_q + m_re;
	assign dsum_i = sum_im_q + m_im;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{rows_m: '0, cols_n: '0, depth_k: '0, op_select: '0,
				alpha_real: 32'sh4000_0000, alpha_imag: '0,
				beta_real: 32'sh4000_0000, beta_imag: '0};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS: cfg_q.rows_m <= cfg_data[DimW-1:0];
				REG_COLS: cfg_q.cols_n <= cfg_data[DimW-1:0];
				REG_DEPTH: cfg_q.depth_k <= cfg_data[DimW-1:0];
				REG_OPSEL: cfg_q.op_select <= cfg_data[3:0];
				REG_ALPHA_RE: cfg_q.alpha_real <= cfg_data;
				REG_ALPHA_IM: cfg_q.alpha_imag <= cfg_data;
				REG_BETA_RE: cfg_q.beta_real <= cfg_data;
				REG_BETA_IM: cfg_q.beta_imag <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline valid tags follow operand reads through RAM latency and the multiplier.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_DOT_RUN);
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Main sequencer with the registered result item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sat_q <= 1'b0;
			out_valid <= 1'b0;
			out_data <= '0;
			m_q <= '0; n_q <= '0; k_q <= '0;
			i_q <= '0; j_q <= '0; l_q <= '0;
			opa_q <= OP_NONE; opb_q <= OP_NONE;
			wait_q <= '0;
			kind_q <= KIND_ACK;
			sum_re_q <= '0; sum_im_q <= '0;
			acc_re_q <= '0; acc_im_q <= '0;
			rdata_q <= '0;
		end else begin
			// In the reply state the valid flag is set below instead.
			if (out_valid && out_ready && state_q != ST_REPLY) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (in_data.action)
							ACT_LOAD_A, ACT_LOAD_B, ACT_LOAD_C: begin
								kind_q <= KIND_ACK;
								rdata_q <= '0;
								state_q <= ST_REPLY;
							end
							ACT_READ_C: begin
								kind_q <= KIND_DATA;
								wait_q <= {3'b0, ld_hit};
								state_q <= ST_READ;
							end
							ACT_COMPUTE: begin
								kind_q <= KIND_DONE;
								sat_q <= 1'b0;
								m_q <= clamp_dim(cfg_q.rows_m);
								n_q <= clamp_dim(cfg_q.cols_n);
								k_q <= clamp_dim(cfg_q.depth_k);
								opa_q <= (cfg_q.op_select[1:0] == 2'd3) ?
									OP_NONE : cfg_q.op_select[1:0];
								opb_q <= (cfg_q.op_select[3:2] == 2'd3) ?
									OP_NONE : cfg_q.op_select[3:2];
								i_q <= '0;
								j_q <= '0;
								if (clamp_dim(cfg_q.rows_m) == 0 ||
										clamp_dim(cfg_q.cols_n) == 0) begin
									rdata_q <= '0;
									state_q <= ST_REPLY;
								end else if (beta_one) begin
									state_q <= ST_DOT_INIT;
								end else begin
									state_q <= ST_BETA_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_READ: begin
					rdata_q <= wait_q[0] ? c_rd : '0;
					state_q <= ST_REPLY;
				end
				ST_BETA_RD: begin
					wait_q <= 4'd3;
					state_q <= ST_BETA_MUL;
				end
				ST_BETA_MUL: begin
					rdata_q <= c_rd;
					wait_q <= 4'd2;
					state_q <= ST_BETA_WR;
				end
				ST_BETA_WR: begin
					if (wait_q != 0) begin
						wait_q <= wait_q - 4'd1;
					end else begin
						if (ovf_r || ovf_i) begin
							sat_q <= 1'b1;
						end
						if (i_q + 1'b1 < m_q) begin
							i_q <= i_q + 1'b1;
							state_q <= ST_BETA_RD;
						end else begin
							i_q <= '0;
							if (j_q + 1'b1 < n_q) begin
								j_q <= j_q + 1'b1;
								state_q <= ST_BETA_RD;
							end else begin
								j_q <= '0;
								state_q <= ST_DOT_INIT;
							end
						end
					end
				end
				ST_DOT_INIT: begin
					if (alpha_zero || k_q == 0) begin
						rdata_q <= '0;
						state_q <= ST_REPLY;
					end else begin
						l_q <= '0;
						sum_re_q <= '0;
						sum_im_q <= '0;
						state_q <= ST_DOT_RUN;
					end
				end
				ST_DOT_RUN: begin
					// One A and one B read per cycle; products arrive tagged by valid_s3.
					if (valid_s3) begin
						sum_re_q <= dsum_r;
						sum_im_q <= dsum_i;
					end
					if (l_q + 1'b1 < k_q) begin
						l_q <= l_q + 1'b1;
					end else begin
						state_q <= ST_DOT_DRAIN;
					end
				end
				ST_DOT_DRAIN: begin
					if (valid_s3) begin
						sum_re_q <= dsum_r;
						sum_im_q <= dsum_i;
					end else if (!valid_s1 && !valid_s2) begin
						if (sum_re_q > 67'(DotLimit)) begin
							acc_re_q <= DotLimit;
							sat_q <= 1'b1;
						end else if (sum_re_q < -67'(DotLimit)) begin
							acc_re_q <= -DotLimit;
							sat_q <= 1'b1;
						end else begin
							acc_re_q <= sum_re_q[33:0];
						end
						if (sum_im_q > 67'(DotLimit)) begin
							acc_im_q <= DotLimit;
							sat_q <= 1'b1;
						end else if (sum_im_q < -67'(DotLimit)) begin
							acc_im_q <= -DotLimit;
							sat_q <= 1'b1;
						end else begin
							acc_im_q <= sum_im_q[33:0];
						end
						wait_q <= 4'd1;
						state_q <= ST_ALPHA_MUL;
					end
				end
				ST_ALPHA_MUL: begin
					// C read issued while in this state; wait for it and the operands.
					if (wait_q != 0) begin
						wait_q <= wait_q - 4'd1;
					end else begin
						rdata_q <= c_rd;
						wait_q <= 4'd1;
						state_q <= ST_ALPHA_WR;
					end
				end
				ST_ALPHA_WR: begin
					if (wait_q != 0) begin
						wait_q <= wait_q - 4'd1;
					end else begin
						if (ovf_r || ovf_i) begin
							sat_q <= 1'b1;
						end
						state_q <= ST_DOT_INIT;
						if (i_q + 1'b1 < m_q) begin
							i_q <= i_q + 1'b1;
						end else begin
							i_q <= '0;
							if (j_q + 1'b1 < n_q) begin
								j_q <= j_q + 1'b1;
							end else begin
								rdata_q <= '0;
								state_q <= ST_REPLY;
							end
						end
					end
				end
				ST_REPLY: begin
					if (!out_valid || out_ready) begin
						out_valid <= 1'b1;
						out_data <= '{reply_kind: kind_q, out_real: rdata_q.re,
							out_imag: rdata_q.im, saturated: sat_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The block takes no item while a read, compute or reply is in flight.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input accepted while busy");

	// A finished reply is held until it is taken.
	a_reply_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result item dropped or changed while stalled");

	// Store writes from compute happen only while a compute is active.
	a_cwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(c_we && state_q != ST_IDLE) |->
			(state_q == ST_BETA_WR || state_q == ST_ALPHA_WR))
		else $error("C write outside a compute pass");
endmodule

// ===== bench/complex_matrix_multiply_accumulate_top_tb.sv =====
// Self-checking testbench for the complex matrix multiply-accumulate block.
module complex_matrix_multiply_accumulate_top_tb;
	import cmma_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// Number of cycles with no accepted item on either side before the run is abandoned.
	localparam int StallLimit = 50000;
	localparam int RandomItems = 1100;
	localparam int Settle = 20;
	localparam logic signed [95:0] DotMax = 96'sd4294967295;
	localparam logic signed [31:0] One = 32'sh4000_0000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_ROWS;
	logic [31:0] cfg_data = '0;

	complex_matrix_multiply_accumulate_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Our own copy of the block's state: three element stores with written flags, the
	// registers, and the saturation flag reported with every reply.
	cplx_t a_mem [MaxDim*MaxDim];
	cplx_t b_mem [MaxDim*MaxDim];
	cplx_t c_mem [MaxDim*MaxDim];
	bit a_wr [MaxDim*MaxDim];
	bit b_wr [MaxDim*MaxDim];
	bit c_wr [MaxDim*MaxDim];
	bit sat_seen = 1'b0;
	int rows_cfg = 0, cols_cfg = 0, depth_cfg = 0;
	logic [3:0] opsel_cfg = '0;
	logic signed [31:0] alpha_re = One, alpha_im = '0, beta_re = One, beta_im = '0;

	out_item_t pending_replies [$];
	int errors = 0;
	int rand_items = 0;
	bit random_phase = 1'b0;
	int burst_left = 0;

	// Rounded fixed-point product, floor((x*y + 2^(F-1)) / 2^F).
	function automatic logic signed [95:0] qmul(input logic signed [95:0] x,
			input logic signed [95:0] y);
		logic signed [95:0] t;
		t = x * y + (96'sd1 <<< (FracBits - 1));
		return t >>> FracBits;
	endfunction

	function automatic void cx_mul(input logic signed [95:0] ar, input logic signed [95:0] ai,
			input logic signed [95:0] br, input logic signed [95:0] bi,
			output logic signed [95:0] re, output logic signed [95:0] im);
		re = qmul(ar, br) - qmul(ai, bi);
		im = qmul(ar, bi) + qmul(ai, br);
	endfunction

	function automatic logic signed [31:0] clip32(input logic signed [95:0] v);
		if (v > 96'sd2147483647) begin
			sat_seen = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -96'sd2147483648) begin
			sat_seen = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [95:0] clip_dot(input logic signed [95:0] v);
		if (v > DotMax) begin
			sat_seen = 1'b1;
			return DotMax;
		end
		if (v < -DotMax) begin
			sat_seen = 1'b1;
			return -DotMax;
		end
		return v;
	endfunction

	function automatic int eff_dim(input int d);
		return (d > MaxDim) ? MaxDim : d;
	endfunction

	// The unused op code behaves as no operation.
	function automatic logic [1:0] eff_op(input logic [1:0] op);
		return (op == OP_TRANS || op == OP_CONJ) ? op : OP_NONE;
	endfunction

	// C = beta*C then, unless alpha or depth is zero, C += alpha * op(A)*op(B).
	function automatic void gemm_update();
		int m, n, k, idx, ia, ib;
		logic [1:0] opa, opb;
		logic signed [95:0] re, im, sr, si, ar, ai, br, bi, dr, di;
		m = eff_dim(rows_cfg);
		n = eff_dim(cols_cfg);
		k = eff_dim(depth_cfg);
		opa = eff_op(opsel_cfg[1:0]);
		opb = eff_op(opsel_cfg[3:2]);
		sat_seen = 1'b0;
		if (m == 0 || n == 0)
			return;
		for (int j = 0; j < n; j++)
			for (int i = 0; i < m; i++) begin
				idx = i * MaxDim + j;
				if (beta_re == 0 && beta_im == 0) begin
					c_mem[idx] = '0;
				end else if (!(beta_re == One && beta_im == 0)) begin
					cx_mul(c_mem[idx].re, c_mem[idx].im, beta_re, beta_im, re, im);
					c_mem[idx].re = clip32(re);
					c_mem[idx].im = clip32(im);
				end
				c_wr[idx] = 1'b1;
			end
		if ((alpha_re == 0 && alpha_im == 0) || k == 0)
			return;
		for (int j = 0; j < n; j++)
			for (int i = 0; i < m; i++) begin
				idx = i * MaxDim + j;
				sr = 0;
				si = 0;
				for (int l = 0; l < k; l++) begin
					ia = (opa == OP_NONE) ? i * MaxDim + l : l * MaxDim + i;
					ib = (opb == OP_NONE) ? l * MaxDim + j : j * MaxDim + l;
					ar = a_mem[ia].re;
					ai = a_mem[ia].im;
					br = b_mem[ib].re;
					bi = b_mem[ib].im;
					if (opa == OP_CONJ)
						ai = -ai;
					if (opb == OP_CONJ)
						bi = -bi;
					cx_mul(ar, ai, br, bi, re, im);
					sr = sr + re;
					si = si + im;
				end
				dr = clip_dot(sr);
				di = clip_dot(si);
				cx_mul(alpha_re, alpha_im, dr, di, re, im);
				c_mem[idx].re = clip32(c_mem[idx].re + re);
				c_mem[idx].im = clip32(c_mem[idx].im + im);
			end
	endfunction

	// Applies one accepted item to our state; returns 1 with the reply if the item has one.
	function automatic bit reply_for(input in_item_t it, output out_item_t r);
		int idx;
		idx = it.row_index * MaxDim + it.col_index;
		r = '0;
		case (it.action)
			ACT_LOAD_A: begin
				a_mem[idx] = {it.value_real, it.value_imag};
				a_wr[idx] = 1'b1;
				r.reply_kind = KIND_ACK;
			end
			ACT_LOAD_B: begin
				b_mem[idx] = {it.value_real, it.value_imag};
				b_wr[idx] = 1'b1;
				r.reply_kind = KIND_ACK;
			end
			ACT_LOAD_C: begin
				c_mem[idx] = {it.value_real, it.value_imag};
				c_wr[idx] = 1'b1;
				r.reply_kind = KIND_ACK;
			end
			ACT_COMPUTE: begin
				gemm_update();
				r.reply_kind = KIND_DONE;
			end
			ACT_READ_C: begin
				r.reply_kind = KIND_DATA;
				r.out_real = c_mem[idx].re;
				r.out_imag = c_mem[idx].im;
			end
			default: return 1'b0;
		endcase
		r.saturated = sat_seen;
		return 1'b1;
	endfunction

	// Offers one item and holds it until the block takes it. The sender runs in bursts
	// of random length; between most bursts valid drops for a random pause.
	task automatic send_item(input in_item_t it, input bit typed = 1'b0,
			input out_item_t typed_reply = '0);
		out_item_t r;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		if (reply_for(it, r))
			pending_replies.push_back(typed ? typed_reply : r);
		if (random_phase && it.action <= ACT_READ_C)
			rand_items++;
		@(negedge clk);
	endtask

	// Drops valid and waits until every reply has come back, then waits out the Settle margin
	// so that an ignored item still in the block has drained before the registers change.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
		repeat (Settle) @(negedge clk);
	endtask

	// Called at a falling edge; the caller lowers the write enable after its last write.
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_ROWS: rows_cfg = val[6:0];
			REG_COLS: cols_cfg = val[6:0];
			REG_DEPTH: depth_cfg = val[6:0];
			REG_OPSEL: opsel_cfg = val[3:0];
			REG_ALPHA_RE: alpha_re = val;
			REG_ALPHA_IM: alpha_im = val;
			REG_BETA_RE: beta_re = val;
			default: beta_im = val;
		endcase
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return One;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return -One;
			5: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 6))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $urandom;
			default: return $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
		endcase
	endfunction

	task automatic send_random(input logic [2:0] act, input int r, input int c);
		in_item_t it;
		it.action = act;
		it.row_index = 6'(r);
		it.col_index = 6'(c);
		it.value_real = pick_value();
		it.value_imag = pick_value();
		send_item(it);
	endtask

	// Loads an element that the next compute reads if it has never been written, and
	// now and then rewrites one anyway. Items the block ignores are mixed in as noise.
	task automatic fill(input logic [2:0] act, input int r, input int c);
		bit known;
		known = (act == ACT_LOAD_A) ? a_wr[r*MaxDim+c] :
			(act == ACT_LOAD_B) ? b_wr[r*MaxDim+c] : c_wr[r*MaxDim+c];
		if (!known || $urandom_range(0, 3) == 0)
			send_random(act, r, c);
		if ($urandom_range(0, 39) == 0)
			send_random(3'($urandom_range(5, 7)), $urandom_range(0, 63), $urandom_range(0, 63));
	endtask

	// One phase: new register settings, the operands that the compute needs, one or two
	// computes, and reads of the updated block of C.
	task automatic run_phase();
		int m, n, k, which, big;
		logic [1:0] opa, opb;
		in_item_t cmd;
		drain();
		which = $urandom_range(0, 19);
		m = $urandom_range(1, 5);
		n = $urandom_range(1, 5);
		k = $urandom_range(1, 5);
		if (which == 0) begin
			case ($urandom_range(0, 2))
				0: m = 0;
				1: n = 0;
				default: k = 0;
			endcase
		end else if (which == 1) begin
			// One dimension at or beyond the store size, the others kept tiny.
			big = $urandom_range(0, 1) ? MaxDim : $urandom_range(MaxDim + 1, 127);
			m = 1;
			n = 1;
			k = 1;
			case ($urandom_range(0, 2))
				0: m = big;
				1: n = big;
				default: k = big;
			endcase
		end
		write_reg(REG_ROWS, m);
		write_reg(REG_COLS, n);
		write_reg(REG_DEPTH, k);
		write_reg(REG_OPSEL, $urandom_range(0, 15));
		write_reg(REG_ALPHA_RE, pick_coef());
		write_reg(REG_ALPHA_IM, $urandom_range(0, 1) ? 32'h0 : pick_coef());
		write_reg(REG_BETA_RE, pick_coef());
		write_reg(REG_BETA_IM, $urandom_range(0, 1) ? 32'h0 : pick_coef());
		cfg_we <= 1'b0;
		m = eff_dim(m);
		n = eff_dim(n);
		k = eff_dim(k);
		opa = eff_op(opsel_cfg[1:0]);
		opb = eff_op(opsel_cfg[3:2]);
		if (!(alpha_re == 0 && alpha_im == 0) && m != 0 && n != 0)
			for (int l = 0; l < k; l++) begin
				for (int i = 0; i < m; i++)
					if (opa == OP_NONE)
						fill(ACT_LOAD_A, i, l);
					else
						fill(ACT_LOAD_A, l, i);
				for (int j = 0; j < n; j++)
					if (opb == OP_NONE)
						fill(ACT_LOAD_B, l, j);
					else
						fill(ACT_LOAD_B, j, l);
			end
		for (int j = 0; j < n; j++)
			for (int i = 0; i < m; i++)
				fill(ACT_LOAD_C, i, j);
		cmd = '0;
		cmd.action = ACT_COMPUTE;
		cmd.row_index = 6'($urandom);
		cmd.col_index = 6'($urandom);
		cmd.value_real = $urandom;
		cmd.value_imag = $urandom;
		for (int pass = 0; pass < 2; pass++) begin
			send_item(cmd);
			if (m != 0 && n != 0)
				repeat ($urandom_range(1, 8))
					send_random(ACT_READ_C, $urandom_range(0, m - 1), $urandom_range(0, n - 1));
			else
				send_random(ACT_READ_C, 0, 0);
			if ($urandom_range(0, 3) != 0)
				break;
		end
	endtask

	// Receiver: the ready pattern is switched at random between always ready, a coin
	// flip per cycle, and ready only one cycle in four.
	int cycle_count = 0;
	int ready_mode = 0;
	always @(negedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 256 == 0)
			ready_mode <= $urandom_range(0, 2);
		case (ready_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Each accepted reply is compared field by field with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: reply with none expected: %p", $time, out_data);
				errors++;
			end else begin
				want = pending_replies.pop_front();
				if (out_data.reply_kind !== want.reply_kind) begin
					$display("%0t: reply_kind expected %0d, got %0d", $time,
						want.reply_kind, out_data.reply_kind);
					errors++;
				end
				if (out_data.out_real !== want.out_real) begin
					$display("%0t: out_real expected %h, got %h", $time,
						want.out_real, out_data.out_real);
					errors++;
				end
				if (out_data.out_imag !== want.out_imag) begin
					$display("%0t: out_imag expected %h, got %h", $time,
						want.out_imag, out_data.out_imag);
					errors++;
				end
				if (out_data.saturated !== want.saturated) begin
					$display("%0t: saturated expected %b, got %b", $time,
						want.saturated, out_data.saturated);
					errors++;
				end
			end
		end
	end

	// Watchdog on progress: any accepted item on either side restarts the count.
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > StallLimit) begin
			$display("%0t: no progress for %0d cycles", $time, StallLimit);
			$display("Test completed with failures");
			$finish;
		end
	end

	// Directed rows: the item, and where the reply is obvious, the reply itself.
	typedef struct {
		in_item_t item;
		bit typed;
		out_item_t reply;
	} dir_row_t;

	dir_row_t dir_rows [$];

	function automatic void add_row(input logic [2:0] act, input logic [5:0] r,
			input logic [5:0] c, input logic [31:0] vr, input logic [31:0] vi,
			input bit typed, input logic [1:0] kind = KIND_ACK,
			input logic [31:0] or_ = '0, input logic [31:0] oi = '0);
		dir_row_t row;
		row.item = {act, r, c, vr, vi};
		row.typed = typed;
		row.reply = {kind, or_, oi, 1'b0};
		dir_rows.push_back(row);
	endfunction

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// After reset every dimension is zero, so a compute is an empty block and
		// leaves the flag clear; loads and reads come straight back.
		add_row(ACT_LOAD_A, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		add_row(ACT_LOAD_B, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1);
		add_row(ACT_LOAD_C, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);
		add_row(ACT_LOAD_C, 63, 63, 32'h0, 32'hFFFF_FFFF, 1);
		add_row(ACT_LOAD_C, 63, 0, 32'h4000_0000, 32'hC000_0000, 1);
		add_row(ACT_LOAD_A, 63, 63, 32'h0, 32'h0, 1);
		add_row(ACT_LOAD_B, 42, 21, 32'h5555_5555, 32'hAAAA_AAAA, 1);
		add_row(ACT_READ_C, 0, 0, 32'h0, 32'h0, 1, KIND_DATA,
			32'h7FFF_FFFF, 32'h8000_0000);
		add_row(ACT_READ_C, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, KIND_DATA,
			32'h0, 32'hFFFF_FFFF);
		add_row(3'd5, 63, 63, 32'h1234_5678, 32'h0, 0);
		add_row(ACT_COMPUTE, 0, 0, 32'h0, 32'h0, 1, KIND_DONE);
		add_row(3'd6, 0, 63, 32'h0, 32'h0, 0);
		add_row(ACT_READ_C, 63, 0, 32'h0, 32'h0, 1, KIND_DATA,
			32'h4000_0000, 32'hC000_0000);
		add_row(3'd7, 21, 42, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		add_row(ACT_LOAD_C, 0, 0, 32'h0000_0001, 32'hFFFF_FFFF, 0);
		add_row(ACT_COMPUTE, 63, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
		add_row(ACT_READ_C, 0, 0, 32'h0, 32'h0, 0);
		foreach (dir_rows[i])
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].reply);

		// Random phases until enough result-bearing items have gone in. Each phase
		// starts by waiting for every reply, which also exercises a full sender pause.
		random_phase = 1'b1;
		while (rand_items < RandomItems)
			run_phase();

		drain();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== complex_matrix_multiply_accumulate_top.f =====
rtl/cmma_pkg.sv
rtl/cmma_ram.sv
rtl/cmma_cmul.sv
rtl/complex_matrix_multiply_accumulate_top.sv
bench/complex_matrix_multiply_accumulate_top_tb.sv
